/* src/tqpi_pkg.sv */
// Package for the two-queue positional insert block.
// Holds shared constants, operation and status codes, the queue command struct
// and the record field mask function. No dependencies.
package tqpi_pkg;

    // Default sizes and fixed field widths.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FIELD_CHARS_DEF = 8;
    localparam int FIELD_W         = 64;
    localparam int POS_W           = 5;
    localparam int COUNT_OUT_W     = 5;

    // Operation codes carried by a request transaction.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_MOVE   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Status codes carried by a response transaction.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Update command for one queue.
    typedef struct packed {
        logic push;
        logic pop;
    } queue_cmd_t;

    // Keeps the low CHARS bytes of a packed character field.
    function automatic logic [FIELD_W-1:0] field_mask(input int chars);
        logic [FIELD_W-1:0] m;
        m = '1;
        if (chars < 8)
        begin
            m = (FIELD_W'(1) << (8 * chars)) - FIELD_W'(1);
        end
        return m;
    endfunction

endpackage

/* src/tqpi_req_if.sv */
// Request channel interface: valid/ready handshake with the operation payload.
// Depends on tqpi_pkg for field widths.
interface tqpi_req_if
    import tqpi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [POS_W-1:0]   position;
    logic               queue_select;
    logic [FIELD_W-1:0] record_id;
    logic [FIELD_W-1:0] record_name;

    modport source (
        output valid, operation, position, queue_select, record_id, record_name,
        input  ready
    );

    modport sink (
        input  valid, operation, position, queue_select, record_id, record_name,
        output ready
    );
endinterface

/* src/tqpi_rsp_if.sv */
// Response channel interface: valid/ready handshake with the result payload.
// Depends on tqpi_pkg for field widths.
interface tqpi_rsp_if
    import tqpi_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] first_count;
    logic [COUNT_OUT_W-1:0] second_count;
    logic [FIELD_W-1:0]     out_id;
    logic [FIELD_W-1:0]     out_name;

    modport source (
        output valid, status, first_count, second_count, out_id, out_name,
        input  ready
    );

    modport sink (
        input  valid, status, first_count, second_count, out_id, out_name,
        output ready
    );
endinterface

/* src/tqpi_first_queue.sv */
// First queue: register array with parallel shift for positional insert and
// head removal, plus a random read port. Depends on tqpi_pkg.
module tqpi_first_queue
    import tqpi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int IW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  queue_cmd_t         cmd,
    input  logic [IW-1:0]      slot,
    input  logic [FIELD_W-1:0] wr_id,
    input  logic [FIELD_W-1:0] wr_name,
    input  logic [IW-1:0]      rd_index,
    output logic [FIELD_W-1:0] rd_id,
    output logic [FIELD_W-1:0] rd_name,
    output logic [FIELD_W-1:0] head_id,
    output logic [FIELD_W-1:0] head_name,
    output logic [CW-1:0]      count
);

    logic [FIELD_W-1:0] ids_reg   [DEPTH];
    logic [FIELD_W-1:0] names_reg [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    // Each entry takes the new record, its lower neighbor on insert, or its
    // upper neighbor on a head removal.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (cmd.push)
            begin
                if (IW'(g) == slot)
                begin
                    ids_reg[g]   <= wr_id;
                    names_reg[g] <= wr_name;
                end
                else if (IW'(g) > slot)
                begin
                    if (g > 0)
                    begin
                        ids_reg[g]   <= ids_reg[(g > 0) ? g - 1 : 0];
                        names_reg[g] <= names_reg[(g > 0) ? g - 1 : 0];
                    end
                end
            end
            else if (cmd.pop)
            begin
                if (g < DEPTH - 1)
                begin
                    ids_reg[g]   <= ids_reg[(g < DEPTH - 1) ? g + 1 : g];
                    names_reg[g] <= names_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    // Occupancy count.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_id     = ids_reg[rd_index];
    assign rd_name   = names_reg[rd_index];
    assign head_id   = ids_reg[0];
    assign head_name = names_reg[0];
    assign count     = count_reg;

endmodule

/* src/tqpi_second_queue.sv */
// Second queue: register array written at its tail, with a random read port.
// Depends on tqpi_pkg.
module tqpi_second_queue
    import tqpi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int IW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [FIELD_W-1:0] wr_id,
    input  logic [FIELD_W-1:0] wr_name,
    input  logic [IW-1:0]      rd_index,
    output logic [FIELD_W-1:0] rd_id,
    output logic [FIELD_W-1:0] rd_name,
    output logic [CW-1:0]      count
);

    logic [FIELD_W-1:0] ids_reg   [DEPTH];
    logic [FIELD_W-1:0] names_reg [DEPTH];
    logic [CW-1:0]      count_reg;

    // Tail write; the count is below DEPTH whenever a push is issued.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ids_reg[count_reg[IW-1:0]]   <= wr_id;
            names_reg[count_reg[IW-1:0]] <= wr_name;
        end
    end

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    assign rd_id   = ids_reg[rd_index];
    assign rd_name = names_reg[rd_index];
    assign count   = count_reg;

endmodule

/* src/two_queue_positional_insert_top.sv */
// Top level of the two-queue positional insert block: request register,
// operation decode, both queues and the response register.
// Depends on tqpi_pkg, tqpi_req_if, tqpi_rsp_if and both queue modules.
//
//   Channel  Direction  Transaction carries
//   req      in         operation, position, queue_select, record_id, record_name
//   rsp      out        status, first_count, second_count, out_id, out_name
//
// Each request passes from acceptance to its response through the request register,
// where decode and queue update run, and then the response register.
// A new request is accepted every cycle while responses are taken.
// Reset clears both queue counts and the valid flags; entry contents are not
// cleared. A stalled response holds the request register, which then stalls req.
module two_queue_positional_insert_top
    import tqpi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tqpi_req_if.sink  req,
    tqpi_rsp_if.source rsp
);

    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [FIELD_W-1:0] MASK = field_mask(FIELD_CHARS);

    // Request register.
    logic               s1_valid_reg;
    op_t                op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               sel_reg;
    logic [FIELD_W-1:0] id_reg;
    logic [FIELD_W-1:0] name_reg;

    // Response register.
    logic                   rsp_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [COUNT_OUT_W-1:0] first_cnt_reg;
    logic [COUNT_OUT_W-1:0] second_cnt_reg;
    logic [FIELD_W-1:0]     oid_reg;
    logic [FIELD_W-1:0]     oid_next;
    logic [FIELD_W-1:0]     oname_reg;
    logic [FIELD_W-1:0]     oname_next;

    logic       advance;
    logic       req_accept;
    queue_cmd_t q1_cmd;
    queue_cmd_t q1_op;
    logic       q2_push;
    logic       q2_push_op;

    logic [IW-1:0]      slot;
    logic [IW-1:0]      rd_index;
    logic [CW-1:0]      cnt1;
    logic [CW-1:0]      cnt2;
    logic [CMPW-1:0]    cnt1_w;
    logic [CMPW-1:0]    cnt2_w;
    logic [CMPW-1:0]    pos_w;
    logic [CMPW-1:0]    ins_pos_w;
    logic [CMPW-1:0]    cnt1_after_w;
    logic [CMPW-1:0]    cnt2_after_w;
    logic [FIELD_W-1:0] q1_rd_id;
    logic [FIELD_W-1:0] q1_rd_name;
    logic [FIELD_W-1:0] q2_rd_id;
    logic [FIELD_W-1:0] q2_rd_name;
    logic [FIELD_W-1:0] head_id;
    logic [FIELD_W-1:0] head_name;

    // Handshake: the request register moves on when the response register frees up.
    assign advance    = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || advance;
    assign req_accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload; record fields are stored already masked.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg   <= op_t'(req.operation);
            pos_reg  <= req.position;
            sel_reg  <= req.queue_select;
            id_reg   <= req.record_id & MASK;
            name_reg <= req.record_name & MASK;
        end
    end

    // Widened operands for count and position compares.
    assign cnt1_w    = CMPW'(cnt1);
    assign cnt2_w    = CMPW'(cnt2);
    assign pos_w     = CMPW'(pos_reg);
    assign ins_pos_w = (pos_reg == '0) ? CMPW'(1) : pos_w;
    assign rd_index  = pos_w[IW-1:0];

    // Insert slot: the given position counted from one (zero acts as one), or the tail when beyond it or on append.
    always_comb
    begin
        slot = cnt1_w[IW-1:0];
        if (op_reg == OP_INSERT && ins_pos_w <= cnt1_w)
        begin
            slot = ins_pos_w[IW-1:0] - IW'(1);
        end
    end

    // Operation decode against the current counts.
    always_comb
    begin
        status_next = ST_OK;
        oid_next    = '0;
        oname_next  = '0;
        q1_op       = '0;
        q2_push_op  = 1'b0;
        unique case (op_reg)
            OP_APPEND, OP_INSERT:
            begin
                if (cnt1_w >= CMPW'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    q1_op.push = 1'b1;
                end
            end
            OP_MOVE:
            begin
                if (cnt1_w == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (cnt2_w >= CMPW'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    q1_op.pop  = 1'b1;
                    q2_push_op = 1'b1;
                    oid_next   = head_id;
                    oname_next = head_name;
                end
            end
            OP_READ:
            begin
                if (pos_w >= (sel_reg ? cnt2_w : cnt1_w))
                begin
                    status_next = ST_RANGE;
                end
                else if (sel_reg)
                begin
                    oid_next   = q2_rd_id;
                    oname_next = q2_rd_name;
                end
                else
                begin
                    oid_next   = q1_rd_id;
                    oname_next = q1_rd_name;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Queues change state only when the request moves into the response register.
    assign q1_cmd.push = q1_op.push && advance;
    assign q1_cmd.pop  = q1_op.pop && advance;
    assign q2_push     = q2_push_op && advance;

    assign cnt1_after_w = cnt1_w + CMPW'(q1_op.push) - CMPW'(q1_op.pop);
    assign cnt2_after_w = cnt2_w + CMPW'(q2_push_op);

    tqpi_first_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q1_cmd),
        .slot      (slot),
        .wr_id     (id_reg),
        .wr_name   (name_reg),
        .rd_index  (rd_index),
        .rd_id     (q1_rd_id),
        .rd_name   (q1_rd_name),
        .head_id   (head_id),
        .head_name (head_name),
        .count     (cnt1)
    );

    tqpi_second_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q2_push),
        .wr_id    (head_id),
        .wr_name  (head_name),
        .rd_index (rd_index),
        .rd_id    (q2_rd_id),
        .rd_name  (q2_rd_name),
        .count    (cnt2)
    );

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg     <= status_next;
            first_cnt_reg  <= cnt1_after_w[COUNT_OUT_W-1:0];
            second_cnt_reg <= cnt2_after_w[COUNT_OUT_W-1:0];
            oid_reg        <= oid_next;
            oname_reg      <= oname_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.first_count  = first_cnt_reg;
    assign rsp.second_count = second_cnt_reg;
    assign rsp.out_id       = oid_reg;
    assign rsp.out_name     = oname_reg;

    // Queue counts never pass the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt1 <= CW'(QUEUE_DEPTH)) && (cnt2 <= CW'(QUEUE_DEPTH)))
        else $error("queue count exceeds depth");

    // A failed operation leaves both queue counts unchanged.
    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (status_next != ST_OK) |=> $stable(cnt1) && $stable(cnt2))
        else $error("failed operation changed a queue count");

    // A successful move shifts one record from the first queue to the second.
    a_move_counts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_MOVE) && (status_next == ST_OK)
        |=> (cnt1 == $past(cnt1) - CW'(1)) && (cnt2 == $past(cnt2) + CW'(1)))
        else $error("move did not transfer exactly one record");

    // A held request stays in the request register until it advances.
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("request dropped while stalled");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for two_queue_positional_insert_top.
// Uses tqpi_pkg, tqpi_req_if and tqpi_rsp_if, and predicts every response
// from its own copy of both record queues.
module testbench;
    import tqpi_pkg::*;

    localparam int DEPTH            = QUEUE_DEPTH_DEF;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int SETTLE_CYCLES    = 8;

    // One expected response transaction.
    typedef struct {
        status_t                status;
        logic [COUNT_OUT_W-1:0] first_count;
        logic [COUNT_OUT_W-1:0] second_count;
        logic [FIELD_W-1:0]     out_id;
        logic [FIELD_W-1:0]     out_name;
    } queue_response_t;

    logic clk;
    logic rst_n;

    tqpi_req_if req_ch ();
    tqpi_rsp_if rsp_ch ();

    two_queue_positional_insert_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted contents of both queues.
    logic [FIELD_W-1:0] first_queue_ids   [DEPTH];
    logic [FIELD_W-1:0] first_queue_names [DEPTH];
    logic [FIELD_W-1:0] second_queue_ids  [DEPTH];
    logic [FIELD_W-1:0] second_queue_names[DEPTH];
    int                 first_queue_len;
    int                 second_queue_len;

    queue_response_t expected_responses[$];
    int              mismatch_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    bit              long_hold_req;
    int              hold_left;
    int              quiet_cycles;

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the predicted queues and returns its response.
    function automatic queue_response_t apply_queue_op(op_t op, logic [POS_W-1:0] pos,
                                                       logic sel, logic [FIELD_W-1:0] id,
                                                       logic [FIELD_W-1:0] name);
        queue_response_t r;
        int              slot;
        int              target;
        int              limit;
        int              i;
        r.status   = ST_OK;
        r.out_id   = '0;
        r.out_name = '0;
        case (op)
            OP_APPEND, OP_INSERT:
            begin
                if (first_queue_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot = first_queue_len;
                    if (op == OP_INSERT)
                    begin
                        // Position zero behaves as the head; past the count means the tail.
                        target = (pos < 1) ? 1 : int'(pos);
                        if (target <= first_queue_len)
                        begin
                            slot = target - 1;
                        end
                    end
                    for (i = first_queue_len; i > slot; i--)
                    begin
                        first_queue_ids[i]   = first_queue_ids[i-1];
                        first_queue_names[i] = first_queue_names[i-1];
                    end
                    first_queue_ids[slot]   = id;
                    first_queue_names[slot] = name;
                    first_queue_len++;
                end
            end
            OP_MOVE:
            begin
                // An empty source is reported before a full destination.
                if (first_queue_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (second_queue_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    r.out_id   = first_queue_ids[0];
                    r.out_name = first_queue_names[0];
                    second_queue_ids[second_queue_len]   = r.out_id;
                    second_queue_names[second_queue_len] = r.out_name;
                    second_queue_len++;
                    for (i = 1; i < first_queue_len; i++)
                    begin
                        first_queue_ids[i-1]   = first_queue_ids[i];
                        first_queue_names[i-1] = first_queue_names[i];
                    end
                    first_queue_len--;
                end
            end
            default:
            begin
                limit = sel ? second_queue_len : first_queue_len;
                if (int'(pos) >= limit || int'(pos) >= DEPTH)
                begin
                    r.status = ST_RANGE;
                end
                else if (sel)
                begin
                    r.out_id   = second_queue_ids[pos];
                    r.out_name = second_queue_names[pos];
                end
                else
                begin
                    r.out_id   = first_queue_ids[pos];
                    r.out_name = first_queue_names[pos];
                end
            end
        endcase
        r.first_count  = COUNT_OUT_W'(first_queue_len);
        r.second_count = COUNT_OUT_W'(second_queue_len);
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Sends one request transaction and records its expected response.
    task automatic send_queue_op(op_t op, logic [POS_W-1:0] pos, logic sel,
                                 logic [FIELD_W-1:0] id, logic [FIELD_W-1:0] name);
        queue_response_t exp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.position     <= pos;
        req_ch.queue_select <= sel;
        req_ch.record_id    <= id;
        req_ch.record_name  <= name;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        exp = apply_queue_op(op, pos, sel, id, name);
        expected_responses.push_back(exp);
    endtask

    // Stops offering requests until every expected response has arrived.
    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_responses.size() != 0);
    endtask

    // Extremes, every operation and the empty and out-of-range cases, in a fixed order.
    task automatic test_directed();
        send_queue_op(OP_READ, 0, 1'b0, '0, '0);
        send_queue_op(OP_READ, 0, 1'b1, '0, '0);
        send_queue_op(OP_MOVE, 0, 1'b0, '0, '0);
        send_queue_op(OP_APPEND, 0, 1'b0, '1, '1);
        send_queue_op(OP_APPEND, 31, 1'b1, '0, '0);
        send_queue_op(OP_INSERT, 0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_queue_op(OP_INSERT, 1, 1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_queue_op(OP_INSERT, 2, 1'b0, random_word(), random_word());
        send_queue_op(OP_INSERT, 31, 1'b0, random_word(), random_word());
        send_queue_op(OP_INSERT, POS_W'(first_queue_len + 1), 1'b0, random_word(),
                      random_word());
        send_queue_op(OP_INSERT, POS_W'(first_queue_len), 1'b0, random_word(), random_word());
        send_queue_op(OP_READ, 0, 1'b0, '0, '0);
        send_queue_op(OP_READ, POS_W'(first_queue_len - 1), 1'b0, '0, '0);
        send_queue_op(OP_READ, POS_W'(first_queue_len), 1'b0, '0, '0);
        send_queue_op(OP_READ, 31, 1'b0, '0, '0);
        send_queue_op(OP_MOVE, 31, 1'b1, '1, '1);
        send_queue_op(OP_READ, 0, 1'b1, '1, '1);
        send_queue_op(OP_READ, 1, 1'b1, '0, '0);
        send_queue_op(OP_READ, 16, 1'b1, '0, '0);
    endtask

    // Mixed random traffic; positions lean toward the occupied part of a queue.
    task automatic test_random_traffic(int count);
        int               pick;
        int               limit;
        logic             sel;
        logic [POS_W-1:0] pos;
        op_t              op;
        repeat (count)
        begin
            pick = $urandom_range(99);
            sel  = $urandom_range(1);
            if (pick < 15)
            begin
                op = OP_APPEND;
            end
            else if (pick < 35)
            begin
                op = OP_INSERT;
            end
            else if (pick < 40)
            begin
                op = OP_MOVE;
            end
            else
            begin
                op = OP_READ;
            end
            if (op == OP_READ)
            begin
                limit = sel ? second_queue_len : first_queue_len;
            end
            else
            begin
                limit = first_queue_len + 1;
            end
            if ($urandom_range(3) != 0)
            begin
                pos = POS_W'($urandom_range(limit));
            end
            else
            begin
                pos = POS_W'($urandom_range(31));
            end
            send_queue_op(op, pos, sel, random_word(), random_word());
        end
    endtask

    // Fills both queues to capacity and reads every entry back.
    task automatic test_queue_limits();
        int i;
        while (first_queue_len < DEPTH)
        begin
            send_queue_op($urandom_range(1) ? OP_INSERT : OP_APPEND,
                          POS_W'($urandom_range(31)), 1'b0, random_word(), random_word());
        end
        send_queue_op(OP_APPEND, 0, 1'b0, random_word(), random_word());
        send_queue_op(OP_INSERT, 1, 1'b0, random_word(), random_word());
        while (second_queue_len < DEPTH)
        begin
            if (first_queue_len == 0)
            begin
                send_queue_op(OP_APPEND, 0, 1'b0, random_word(), random_word());
            end
            else
            begin
                send_queue_op(OP_MOVE, 0, 1'b0, random_word(), random_word());
            end
        end
        while (first_queue_len < DEPTH)
        begin
            send_queue_op(OP_INSERT, POS_W'($urandom_range(first_queue_len + 1)), 1'b0,
                          random_word(), random_word());
        end
        send_queue_op(OP_MOVE, 0, 1'b0, '0, '0);
        for (i = 0; i <= DEPTH; i++)
        begin
            send_queue_op(OP_READ, POS_W'(i), 1'b0, '0, '0);
            send_queue_op(OP_READ, POS_W'(i), 1'b1, '0, '0);
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        test_random_traffic(40);
    endtask

    // Sender pauses until the block has answered everything.
    task automatic test_drain_pause();
        wait_for_responses();
        test_random_traffic(20);
    endtask

    // Compares one response field and reports a mismatch.
    task automatic compare_field(string field, logic [FIELD_W-1:0] expv,
                                 logic [FIELD_W-1:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expv, actv);
            mismatch_count++;
        end
    endtask

    // Response checking and receiver ready generation.
    always @(posedge clk)
    begin
        queue_response_t exp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("unexpected response transaction, status %0d", rsp_ch.status);
                mismatch_count++;
            end
            else
            begin
                exp = expected_responses.pop_front();
                compare_field("status", FIELD_W'(exp.status), FIELD_W'(rsp_ch.status));
                compare_field("first_count", FIELD_W'(exp.first_count),
                              FIELD_W'(rsp_ch.first_count));
                compare_field("second_count", FIELD_W'(exp.second_count),
                              FIELD_W'(rsp_ch.second_count));
                compare_field("out_id", exp.out_id, rsp_ch.out_id);
                compare_field("out_name", exp.out_name, rsp_ch.out_name);
            end
        end
        if (long_hold_req)
        begin
            hold_left     = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_APPEND;
        req_ch.position     = '0;
        req_ch.queue_select = 1'b0;
        req_ch.record_id    = '0;
        req_ch.record_name  = '0;
        rsp_ch.ready        = 1'b0;
        first_queue_len     = 0;
        second_queue_len    = 0;
        mismatch_count      = 0;
        long_hold_req       = 1'b0;
        hold_left           = 0;
        quiet_cycles        = 0;
        send_idle_pct       = 16;
        recv_idle_pct       = 53;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(450);
        test_backpressure();
        test_drain_pause();

        send_idle_pct = 53;
        recv_idle_pct = 16;
        test_queue_limits();
        test_random_traffic(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(450);

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
